@@ sv/crra_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crra_pkg
// Shared types and constants for the credit round-robin arbiter.
// ----------------------------------------------------------------------------
package crra_pkg;

   // Default structure
   localparam int PORTS_DEFAULT       = 4;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // Fixed field widths
   localparam int MASK_PORTS     = 4;
   localparam int PORT_W         = 2;
   localparam int PRIV_W         = 8;
   localparam int SHARED_LIMIT_W = 16;
   localparam int IN_USE_W       = 16;
   localparam int CSR_DATA_W     = 16;
   localparam int CSR_INDEX_W    = 1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_PRIVATE_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SHARED_LIMIT  = 1'd1;

   // Reset values
   localparam logic [PRIV_W-1:0]         PRIVATE_LIMIT_RESET = 8'd1;
   localparam logic [SHARED_LIMIT_W-1:0] SHARED_LIMIT_RESET  = 16'd0;

   // Per-lane status toward the merge stage and shared counter
   typedef struct packed {
      logic eligible;         // request, no contention, credit available
      logic use_private;      // a grant here consumes a private credit
      logic return_to_shared; // return hits this lane with no private held
   } lane_status_type;

endpackage
`default_nettype wire

@@ sv/crra_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crra_lane
// One port: private credit counter, return handling and eligibility.
// ----------------------------------------------------------------------------
module crra_lane #(
   parameter int LANE = 0
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                accept,
   input  wire logic                                return_valid,
   input  wire logic [crra_pkg::PORT_W-1:0]         return_port,
   input  wire logic                                request,
   input  wire logic                                contention,
   input  wire logic                                shared_free,
   input  wire logic                                grant,
   input  wire logic [crra_pkg::PRIV_W-1:0]         private_limit,
   output crra_pkg::lane_status_type                status
);

   logic [crra_pkg::PRIV_W-1:0] priv_ff;
   logic [crra_pkg::PRIV_W-1:0] priv_in;
   logic [crra_pkg::PRIV_W-1:0] priv_ret;
   logic                        hit;
   logic                        has_priv;

   // Lanes past the mask width never see a return.
   assign hit = return_valid && (LANE < crra_pkg::MASK_PORTS) &&
                (return_port == crra_pkg::PORT_W'(LANE));

   always_comb begin
      priv_ret = priv_ff - crra_pkg::PRIV_W'(hit && (priv_ff != '0));
      has_priv = priv_ret < private_limit;
      priv_in  = priv_ret + crra_pkg::PRIV_W'(grant && has_priv);
      status.eligible         = request && !contention && (has_priv || shared_free);
      status.use_private      = has_priv;
      status.return_to_shared = hit && (priv_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         priv_ff <= '0;
      end else if (accept) begin
         priv_ff <= priv_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/crra_pick.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crra_pick
// Merge stage: round-robin pick among eligible lanes after the last grant.
// ----------------------------------------------------------------------------
module crra_pick #(
   parameter int PORTS = crra_pkg::PORTS_DEFAULT
) (
   input  wire logic [PORTS-1:0]         eligible,
   input  wire logic [$clog2(PORTS)-1:0] last_granted,
   input  wire logic                     enable,
   output logic                          grant_valid,
   output logic [$clog2(PORTS)-1:0]      grant_port,
   output logic [PORTS-1:0]              grant_onehot
);

   localparam int PW = $clog2(PORTS);

   always_comb begin
      int idx;
      grant_valid  = 1'b0;
      grant_port   = '0;
      grant_onehot = '0;
      // Highest offset first so the nearest eligible lane wins.
      for (int i = PORTS - 1; i >= 0; i--) begin
         idx = int'(last_granted) + 1 + i;
         if (idx >= PORTS) begin
            idx = idx - PORTS;
         end
         if (enable && eligible[idx]) begin
            grant_valid = 1'b1;
            grant_port  = PW'(idx);
         end
      end
      if (grant_valid) begin
         grant_onehot[grant_port] = 1'b1;
      end
   end

endmodule
`default_nettype wire

@@ sv/credit_round_robin_arbiter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// credit_round_robin_arbiter
// Round-robin memory arbiter with per-port private credits and a shared pool.
// ----------------------------------------------------------------------------
// Response: an accepted beat appears on the response side in the cycle after.
// Throughput: one beat per cycle unless the response stalls; all credit math
//   is done in the accept cycle, so state is ready at the following edge.
// Reset (synchronous): private counts and shared count cleared, last grant set
//   to the highest port, private limit 1, shared limit 0 (unlimited).
// ----------------------------------------------------------------------------
module credit_round_robin_arbiter #(
   parameter int PORTS       = crra_pkg::PORTS_DEFAULT,
   parameter int COUNT_WIDTH = crra_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_return_valid,
   input  wire logic [crra_pkg::PORT_W-1:0]           req_return_port,
   input  wire logic [crra_pkg::MASK_PORTS-1:0]       req_request_mask,
   input  wire logic [crra_pkg::MASK_PORTS-1:0]       req_contention_mask,
   input  wire logic                                  req_memory_full,
   // response channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_grant_valid,
   output logic [crra_pkg::PORT_W-1:0]                rsp_grant_port,
   output logic                                       rsp_return_error,
   output logic [crra_pkg::IN_USE_W-1:0]              rsp_shared_in_use,
   // configuration
   input  wire logic                                  csr_write_enable,
   input  wire logic [crra_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [crra_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int PW    = $clog2(PORTS);
   // Compare width covers both the count and the 16-bit limit register.
   localparam int CMP_W = (COUNT_WIDTH > crra_pkg::SHARED_LIMIT_W) ?
                          COUNT_WIDTH : crra_pkg::SHARED_LIMIT_W;

   // Configuration registers
   logic [crra_pkg::PRIV_W-1:0]         private_limit_ff;
   logic [crra_pkg::SHARED_LIMIT_W-1:0] shared_limit_ff;

   // Arbiter state
   logic [COUNT_WIDTH-1:0] shared_ff;
   logic [COUNT_WIDTH-1:0] shared_in;
   logic [PW-1:0]          last_granted_ff;
   logic [PW-1:0]          last_granted_in;

   // Response register
   logic                                rsp_valid_ff;
   logic                                rsp_grant_valid_ff;
   logic [crra_pkg::PORT_W-1:0]         rsp_grant_port_ff;
   logic                                rsp_return_error_ff;
   logic [crra_pkg::IN_USE_W-1:0]       rsp_shared_in_use_ff;

   logic accept;

   // Lane and merge signals
   crra_pkg::lane_status_type status [PORTS];
   logic [PORTS-1:0]       eligible;
   logic [PORTS-1:0]       use_private;
   logic [PORTS-1:0]       return_to_shared;
   logic [PORTS-1:0]       grant_onehot;
   logic                   grant_valid;
   logic [PW-1:0]          grant_port;

   logic                   ret_shared;
   logic                   ret_error;
   logic                   shared_dec;
   logic                   use_shared;
   logic                   shared_free;
   logic [COUNT_WIDTH-1:0] shared_ret;

   // Response register frees up when empty or being drained this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // ---------------------------------------------------------------------
   // Configuration writes
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         private_limit_ff <= crra_pkg::PRIVATE_LIMIT_RESET;
         shared_limit_ff  <= crra_pkg::SHARED_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            crra_pkg::REG_PRIVATE_LIMIT: begin
               private_limit_ff <= csr_data[crra_pkg::PRIV_W-1:0];
            end
            crra_pkg::REG_SHARED_LIMIT: begin
               shared_limit_ff <= csr_data[crra_pkg::SHARED_LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Credit return against the shared pool. A return lands on the shared
   // pool only when the returning port holds no private credit; with the
   // pool empty as well, it is flagged and nothing changes.
   // ---------------------------------------------------------------------
   always_comb begin
      ret_shared = |return_to_shared;
      ret_error  = ret_shared && (shared_ff == '0);
      shared_dec = ret_shared && (shared_ff != '0);
      shared_ret = shared_ff - COUNT_WIDTH'(shared_dec);
      // A saturated count is never free, so the count cannot wrap; a limit
      // above the count range then behaves as the range maximum.
      shared_free = (shared_ret != '1) &&
                    ((shared_limit_ff == '0) ||
                     (CMP_W'(shared_ret) < CMP_W'(shared_limit_ff)));
   end

   // ---------------------------------------------------------------------
   // Lanes: one per port, each with its own private counter
   // ---------------------------------------------------------------------
   for (genvar p = 0; p < PORTS; p++) begin : g_lane
      logic lane_req;
      logic lane_cont;

      // Ports beyond the mask width never request.
      assign lane_req  = (p < crra_pkg::MASK_PORTS) &&
                         req_request_mask[p % crra_pkg::MASK_PORTS];
      assign lane_cont = (p < crra_pkg::MASK_PORTS) &&
                         req_contention_mask[p % crra_pkg::MASK_PORTS];

      crra_lane #(
         .LANE (p)
      ) u_lane (
         .clock         (clock),
         .reset         (reset),
         .accept        (accept),
         .return_valid  (req_return_valid),
         .return_port   (req_return_port),
         .request       (lane_req),
         .contention    (lane_cont),
         .shared_free   (shared_free),
         .grant         (grant_onehot[p]),
         .private_limit (private_limit_ff),
         .status        (status[p])
      );

      assign eligible[p]         = status[p].eligible;
      assign use_private[p]      = status[p].use_private;
      assign return_to_shared[p] = status[p].return_to_shared;
   end

   // ---------------------------------------------------------------------
   // Merge: round-robin pick, blocked while memory is full
   // ---------------------------------------------------------------------
   crra_pick #(
      .PORTS (PORTS)
   ) u_pick (
      .eligible     (eligible),
      .last_granted (last_granted_ff),
      .enable       (!req_memory_full),
      .grant_valid  (grant_valid),
      .grant_port   (grant_port),
      .grant_onehot (grant_onehot)
   );

   // Grant draws from the shared pool when the winner has no private credit.
   assign use_shared      = |(grant_onehot & ~use_private);
   assign shared_in       = shared_ret + COUNT_WIDTH'(use_shared);
   assign last_granted_in = grant_valid ? grant_port : last_granted_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shared_ff       <= '0;
         last_granted_ff <= PW'(PORTS - 1);
      end else if (accept) begin
         shared_ff       <= shared_in;
         last_granted_ff <= last_granted_in;
      end
   end

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_grant_valid_ff   <= grant_valid;
         rsp_grant_port_ff    <= crra_pkg::PORT_W'(grant_port);
         rsp_return_error_ff  <= ret_error;
         rsp_shared_in_use_ff <= crra_pkg::IN_USE_W'(shared_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_grant_valid   = rsp_grant_valid_ff;
   assign rsp_grant_port    = rsp_grant_port_ff;
   assign rsp_return_error  = rsp_return_error_ff;
   assign rsp_shared_in_use = rsp_shared_in_use_ff;

endmodule
`default_nettype wire
